[src/rlpb_pkg.sv]
// Package for the run-length pixel blitter decoder.
// Holds the shared widths, codes and structs. Depends on nothing.

package rlpb_pkg;

	localparam int AddrW  = 22;
	localparam int RowW   = 9;
	localparam int ColW   = 16;
	localparam int CfgIdxW = 3;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] KIND_SPAN  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [3:0] CMD_STOP     = 4'd0;
	localparam logic [3:0] CMD_LAST_RUN = 4'd11;
	localparam logic [3:0] CMD_COUNT    = 4'd12;
	localparam logic [3:0] CMD_SKIP     = 4'd13;
	localparam logic [3:0] CMD_NOP      = 4'd14;
	localparam logic [3:0] CMD_ROW      = 4'd15;

	localparam logic [CfgIdxW-1:0] REG_START_COLUMN   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START_ROW      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BLIT_FLAGS     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LAYER_MASK     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OVERRIDE_PEN   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_FLIP           = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SOURCE_ADDRESS = 3'd6;

	localparam int FLAG_CLEAR    = 0;
	localparam int FLAG_OVERRIDE = 1;
	localparam int FLAG_SWAP     = 3;

	typedef struct packed {
		logic [7:0]       start_column;
		logic [7:0]       start_row;
		logic [7:0]       blit_flags;
		logic [5:0]       layer_mask;
		logic [3:0]       override_pen;
		logic             flip;
		logic [AddrW-1:0] source_address;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       first_column;
		logic [7:0]       first_row;
		logic [7:0]       span_length;
		logic             descending;
		logic             along_rows;
		logic [3:0]       span_pen;
		logic [5:0]       target_layers;
		logic [AddrW-1:0] end_address;
	} result_t;

	typedef struct packed {
		logic [ColW-1:0] column;
		logic [RowW-1:0] row;
		logic [7:0]      count;
		logic [3:0]      pen;
	} span_req_t;

endpackage

[src/rlpb_if.sv]
// Channel interfaces for the run-length pixel blitter decoder.
// Depends on rlpb_pkg for widths.

interface rlpb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] source_byte;
	modport source (output valid, mode, source_byte, input ready);
	modport sink (input valid, mode, source_byte, output ready);
endinterface

interface rlpb_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [7:0]                 first_column;
	logic [7:0]                 first_row;
	logic [7:0]                 span_length;
	logic                       descending;
	logic                       along_rows;
	logic [3:0]                 span_pen;
	logic [5:0]                 target_layers;
	logic [rlpb_pkg::AddrW-1:0] end_address;
	modport source (output valid, kind, first_column, first_row, span_length, descending,
		along_rows, span_pen, target_layers, end_address, input ready);
	modport sink (input valid, kind, first_column, first_row, span_length, descending,
		along_rows, span_pen, target_layers, end_address, output ready);
endinterface

interface rlpb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rlpb_pkg::CfgIdxW-1:0] index;
	logic [rlpb_pkg::AddrW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/rlpb_clip.sv]
// Span clipping for the blitter: applies flip, X/Y swap, pen override and
// clipping to the 0..255 screen. Depends on rlpb_pkg.

module rlpb_clip (
	input  rlpb_pkg::span_req_t req,
	input  rlpb_pkg::cfg_t      cfg,
	output logic                visible,
	output rlpb_pkg::result_t   span
);

	logic [rlpb_pkg::ColW:0]   last;
	logic [rlpb_pkg::ColW-1:0] lo;
	logic [8:0]                hi;
	logic                      empty_f;
	logic [8:0]                len_f;
	logic [8:0]                first_f;
	logic [8:0]                sy_f;
	logic [8:0]                rem;
	logic [8:0]                len_n;
	logic [7:0]                first;
	logic [7:0]                sy;
	logic [7:0]                len;
	logic                      row_ok;

	always_comb begin
		last    = {1'b0, req.column} + 17'(req.count) - 17'd1;
		lo      = (req.column == '0) ? 16'd1 : req.column;
		hi      = (last > 17'h100) ? 9'h100 : last[8:0];
		empty_f = {7'd0, hi} < lo;
		len_f   = hi - lo[8:0] + 9'd1;
		first_f = 9'h100 - lo[8:0];
		sy_f    = 9'h100 - req.row;
		rem     = 9'h100 - {1'b0, req.column[7:0]};
		len_n   = (rem < {1'b0, req.count}) ? rem : {1'b0, req.count};
		row_ok  = req.row <= 9'hff;

		if (cfg.flip) begin
			visible = (req.count != '0) && row_ok && (req.row != '0) && !empty_f;
			first   = first_f[7:0];
			sy      = sy_f[7:0];
			len     = len_f[7:0];
		end else begin
			visible = (req.count != '0) && row_ok && (req.column <= 16'hff);
			first   = req.column[7:0];
			sy      = req.row[7:0];
			len     = len_n[7:0];
		end

		span               = '0;
		span.kind          = rlpb_pkg::KIND_SPAN;
		span.span_length   = len;
		span.descending    = cfg.flip;
		span.along_rows    = cfg.blit_flags[rlpb_pkg::FLAG_SWAP];
		span.span_pen      = cfg.blit_flags[rlpb_pkg::FLAG_OVERRIDE] ? cfg.override_pen : req.pen;
		span.target_layers = cfg.layer_mask;
		if (cfg.blit_flags[rlpb_pkg::FLAG_SWAP]) begin
			span.first_column = sy;
			span.first_row    = first;
		end else begin
			span.first_column = first;
			span.first_row    = sy;
		end
	end

endmodule

[src/rlpb_core.sv]
// Command decoder of the blitter: input register, blit state and result register.
// Depends on rlpb_pkg, rlpb_if and rlpb_clip.

module rlpb_core #(
	parameter int ROW_LIMIT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rlpb_pkg::cfg_t     cfg,
	rlpb_in_if.sink            cmd,
	rlpb_out_if.source         res
);

	typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_SKIP, PH_COUNT} phase_t;

	localparam logic [rlpb_pkg::RowW-1:0] RowLim = ROW_LIMIT[rlpb_pkg::RowW-1:0];

	logic                       valid_s1;
	logic [1:0]                 mode_s1;
	logic [7:0]                 byte_s1;
	logic                       advance;

	phase_t                     phase_q, phase_d;
	logic [rlpb_pkg::AddrW-1:0] fetch_q, fetch_d;
	logic [rlpb_pkg::RowW-1:0]  row_q, row_d;
	logic [rlpb_pkg::ColW-1:0]  col_q, col_d;
	logic [3:0]                 pen_q, pen_d;

	logic                       emit;
	rlpb_pkg::result_t          result;
	logic                       res_valid_q;
	rlpb_pkg::result_t          res_q;

	rlpb_pkg::span_req_t        req;
	logic                       visible;
	rlpb_pkg::result_t          span;
	logic [3:0]                 op;
	logic [rlpb_pkg::ColW:0]    col_sum;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1 <= cmd.mode;
			byte_s1 <= cmd.source_byte;
		end
	end

	assign op         = byte_s1[3:0];
	assign req.column = col_q;
	assign req.row    = row_q;
	assign req.count  = (phase_q == PH_COUNT) ? byte_s1 : {4'd0, op};
	assign req.pen    = (phase_q == PH_COUNT) ? pen_q : byte_s1[7:4];
	assign col_sum    = {1'b0, col_q} + 17'(req.count);

	rlpb_clip u_clip (
		.req     (req),
		.cfg     (cfg),
		.visible (visible),
		.span    (span)
	);

	always_comb begin
		phase_d = phase_q;
		fetch_d = fetch_q;
		row_d   = row_q;
		col_d   = col_q;
		pen_d   = pen_q;
		emit    = 1'b0;
		result  = '0;
		result.target_layers = cfg.layer_mask;

		if (mode_s1 == rlpb_pkg::MODE_START) begin
			fetch_d = cfg.source_address;
			row_d   = {1'b0, cfg.start_row};
			col_d   = {8'd0, cfg.start_column};
			pen_d   = '0;
			if (cfg.blit_flags[rlpb_pkg::FLAG_CLEAR]) begin
				phase_d          = PH_IDLE;
				emit             = 1'b1;
				result.kind      = rlpb_pkg::KIND_CLEAR;
				result.first_row = cfg.start_row;
			end else if ({1'b0, cfg.start_row} >= RowLim) begin
				phase_d            = PH_IDLE;
				emit               = 1'b1;
				result.kind        = rlpb_pkg::KIND_DONE;
				result.end_address = cfg.source_address;
			end else begin
				phase_d = PH_CMD;
			end
		end else if (phase_q != PH_IDLE && mode_s1 == rlpb_pkg::MODE_END) begin
			phase_d            = PH_IDLE;
			emit               = 1'b1;
			result.kind        = rlpb_pkg::KIND_DONE;
			result.end_address = fetch_q;
		end else if (phase_q != PH_IDLE && mode_s1 == rlpb_pkg::MODE_BYTE) begin
			fetch_d = fetch_q + 22'd1;
			result.end_address = fetch_d;
			case (phase_q)
				PH_SKIP: begin
					col_d   = {7'd0, 9'(cfg.start_column) + 9'(byte_s1)};
					phase_d = PH_COUNT;
				end
				PH_COUNT: begin
					phase_d = PH_CMD;
					col_d   = col_sum[rlpb_pkg::ColW] ? '1 : col_sum[rlpb_pkg::ColW-1:0];
					emit    = visible;
					result  = span;
				end
				default: begin
					if (op == rlpb_pkg::CMD_STOP) begin
						phase_d     = PH_IDLE;
						emit        = 1'b1;
						result.kind = rlpb_pkg::KIND_DONE;
					end else if (op <= rlpb_pkg::CMD_LAST_RUN) begin
						col_d  = col_sum[rlpb_pkg::ColW] ? '1 : col_sum[rlpb_pkg::ColW-1:0];
						emit   = visible;
						result = span;
					end else if (op == rlpb_pkg::CMD_COUNT) begin
						pen_d   = byte_s1[7:4];
						phase_d = PH_COUNT;
					end else if (op == rlpb_pkg::CMD_SKIP) begin
						pen_d   = byte_s1[7:4];
						phase_d = PH_SKIP;
					end else if (op == rlpb_pkg::CMD_ROW) begin
						row_d = row_q + 9'd1;
						col_d = {8'd0, cfg.start_column};
						if (row_d >= RowLim) begin
							phase_d     = PH_IDLE;
							emit        = 1'b1;
							result.kind = rlpb_pkg::KIND_DONE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			fetch_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pen_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			fetch_q     <= fetch_d;
			row_q       <= row_d;
			col_q       <= col_d;
			pen_q       <= pen_d;
			res_valid_q <= emit;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.kind          = res_q.kind;
	assign res.first_column  = res_q.first_column;
	assign res.first_row     = res_q.first_row;
	assign res.span_length   = res_q.span_length;
	assign res.descending    = res_q.descending;
	assign res.along_rows    = res_q.along_rows;
	assign res.span_pen      = res_q.span_pen;
	assign res.target_layers = res_q.target_layers;
	assign res.end_address   = res_q.end_address;

endmodule

[src/run_length_pixel_blitter_decoder.sv]
// Top level of the run-length pixel blitter decoder: configuration registers
// and the command decoder. Depends on rlpb_pkg, rlpb_if and rlpb_core.
//
// The cmd channel takes one word per cycle: a start word (mode 0), a byte read
// from graphics memory (mode 1) or an end-of-memory mark (mode 2). The res
// channel returns at most one word per input word: a pixel span, a clear
// request or a done word with the end address. The cfg channel writes the
// seven blit registers by index and is always ready; write it only while the
// block has no word in flight.
// A word is registered on acceptance and decoded into the result register when
// it is free or being taken. Throughput is one word per cycle, set by the single
// decode stage, while the receiver does not stall.
// When the receiver stalls, the result register holds its word, the input
// register fills, and cmd.ready drops until the result is taken.
// Reset clears valid flags, state and cfg; the blitter idles, no clearing pass.

module run_length_pixel_blitter_decoder #(
	parameter int ROW_LIMIT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	rlpb_in_if.sink    cmd,
	rlpb_out_if.source res,
	rlpb_cfg_if.sink   cfg
);

	rlpb_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rlpb_pkg::REG_START_COLUMN:   cfg_q.start_column   <= cfg.data[7:0];
				rlpb_pkg::REG_START_ROW:      cfg_q.start_row      <= cfg.data[7:0];
				rlpb_pkg::REG_BLIT_FLAGS:     cfg_q.blit_flags     <= cfg.data[7:0];
				rlpb_pkg::REG_LAYER_MASK:     cfg_q.layer_mask     <= cfg.data[5:0];
				rlpb_pkg::REG_OVERRIDE_PEN:   cfg_q.override_pen   <= cfg.data[3:0];
				rlpb_pkg::REG_FLIP:           cfg_q.flip           <= cfg.data[0];
				rlpb_pkg::REG_SOURCE_ADDRESS: cfg_q.source_address <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	rlpb_core #(
		.ROW_LIMIT (ROW_LIMIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.res    (res)
	);

endmodule

[src/rlpb_checker.sv]
// Port checker for the run-length pixel blitter decoder, bound to the top level.
// Depends on rlpb_pkg.

module rlpb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [1:0]                 kind,
	input logic [7:0]                 first_column,
	input logic [7:0]                 span_length,
	input logic [3:0]                 span_pen,
	input logic [rlpb_pkg::AddrW-1:0] end_address
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result word dropped while stalled.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kind <= rlpb_pkg::KIND_DONE)
		else $error("Result kind out of range.");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rlpb_pkg::KIND_SPAN |-> span_length != '0 && end_address == '0)
		else $error("Span word is empty or carries an address.");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rlpb_pkg::KIND_CLEAR |->
		span_length == '0 && span_pen == '0 && end_address == '0)
		else $error("Clear word carries span fields.");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == rlpb_pkg::KIND_DONE |->
		first_column == '0 && span_length == '0 && span_pen == '0)
		else $error("Done word carries span fields.");

endmodule

bind run_length_pixel_blitter_decoder rlpb_checker u_rlpb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.kind         (res.kind),
	.first_column (res.first_column),
	.span_length  (res.span_length),
	.span_pen     (res.span_pen),
	.end_address  (res.end_address)
);
